### design/wlld_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlld_pkg
// Shared types, codes and helpers of the weighted least-load dispatcher.
// ----------------------------------------------------------------------------
package wlld_pkg;

    // Fixed widths of the beat fields and of the internal arithmetic.
    localparam int SERVERS  = 3;
    localparam int SRV_W    = 2;
    localparam int KIND_W   = 2;
    localparam int LEN_W    = 4;
    localparam int WGT_W    = 3;
    localparam int COST_W   = 7;
    localparam int LOAD_W   = 16;
    localparam int SUM_W    = 17;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 6;
    localparam int CFG_IDX_W = 3;

    // Operation codes of an input beat.
    localparam logic ACT_DISPATCH = 1'b0;
    localparam logic ACT_COMPLETE = 1'b1;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_M   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_P   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_V   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

    // Server numbers with a special meaning.
    localparam logic [SRV_W-1:0] SRV_FIRST = 2'd0;
    localparam logic [SRV_W-1:0] SRV_ONE   = 2'd1;
    localparam logic [SRV_W-1:0] SRV_BACK  = 2'd2;
    localparam logic [SRV_W-1:0] SRV_NONE  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_KIND   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_M_FRONT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_P_FRONT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_V_FRONT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_BACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_P_BACK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_V_BACK  = 3'd5;

    // Weight set held by the configuration registers.
    typedef struct packed {
        logic [WGT_W-1:0] m_front;
        logic [WGT_W-1:0] p_front;
        logic [WGT_W-1:0] v_front;
        logic [WGT_W-1:0] m_back;
        logic [WGT_W-1:0] p_back;
        logic [WGT_W-1:0] v_back;
    } weights_t;

    // Loads of all servers.
    typedef logic [SERVERS-1:0][LOAD_W-1:0] loads_t;

    // Outcome of the least-load choice.
    typedef struct packed {
        logic [SRV_W-1:0] server;
        logic [SUM_W-1:0] sum;
    } pick_t;

    // Weight of a kind on the front servers or on the back server.
    function automatic logic [WGT_W-1:0] weight_of(input weights_t w, input logic back,
                                                   input logic [KIND_W-1:0] kind);
        logic [WGT_W-1:0] wt;
        unique case (kind)
            KIND_M:  wt = back ? w.m_back : w.m_front;
            KIND_P:  wt = back ? w.p_back : w.p_front;
            default: wt = back ? w.v_back : w.v_front;
        endcase
        return wt;
    endfunction

    // Cost of a request: weight times length.
    function automatic logic [COST_W-1:0] cost_of(input logic [WGT_W-1:0] wt,
                                                  input logic [LEN_W-1:0] len);
        return COST_W'(wt) * COST_W'(len);
    endfunction

endpackage

### design/wlld_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlld_cfg_regs
// Weight registers written through the configuration channel.
// ----------------------------------------------------------------------------
module wlld_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wlld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wlld_pkg::WGT_W-1:0]        cfg_data,
    output wlld_pkg::weights_t                weights
);

    wlld_pkg::weights_t weights_reg;

    // Writes are always taken; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;
    assign weights   = weights_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weights_reg.m_front <= 3'd2;
            weights_reg.p_front <= 3'd1;
            weights_reg.v_front <= 3'd1;
            weights_reg.m_back  <= 3'd1;
            weights_reg.p_back  <= 3'd2;
            weights_reg.v_back  <= 3'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                wlld_pkg::CFG_M_FRONT: weights_reg.m_front <= cfg_data;
                wlld_pkg::CFG_P_FRONT: weights_reg.p_front <= cfg_data;
                wlld_pkg::CFG_V_FRONT: weights_reg.v_front <= cfg_data;
                wlld_pkg::CFG_M_BACK:  weights_reg.m_back  <= cfg_data;
                wlld_pkg::CFG_P_BACK:  weights_reg.p_back  <= cfg_data;
                wlld_pkg::CFG_V_BACK:  weights_reg.v_back  <= cfg_data;
                default:               weights_reg         <= weights_reg;
            endcase
        end
    end

endmodule

### design/wlld_queue_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlld_queue_mem
// Pending request store: one FIFO ring per server in a synchronous memory.
// ----------------------------------------------------------------------------
module wlld_queue_mem #(
    parameter int DEPTH = 256,
    parameter int PTR_W = 8
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [wlld_pkg::SRV_W-1:0]        wr_srv,
    input  logic [PTR_W-1:0]                  wr_ptr,
    input  logic [wlld_pkg::ENTRY_W-1:0]      wr_data,
    input  logic                              rd_en,
    input  logic [wlld_pkg::SRV_W-1:0]        rd_srv,
    input  logic [PTR_W-1:0]                  rd_ptr,
    output logic [wlld_pkg::ENTRY_W-1:0]      rd_data
);

    logic [wlld_pkg::ENTRY_W-1:0] mem [wlld_pkg::SERVERS][DEPTH];
    logic [wlld_pkg::ENTRY_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_srv][wr_ptr] <= wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_srv][rd_ptr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/wlld_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlld_pick
// Cost of a request on each server and choice of the least loaded one.
// ----------------------------------------------------------------------------
module wlld_pick (
    input  wlld_pkg::weights_t                weights,
    input  wlld_pkg::loads_t                  loads,
    input  logic [wlld_pkg::KIND_W-1:0]       kind,
    input  logic [wlld_pkg::LEN_W-1:0]        len,
    output wlld_pkg::pick_t                   pick
);

    logic [wlld_pkg::COST_W-1:0] cost [wlld_pkg::SERVERS];
    logic [wlld_pkg::SUM_W-1:0]  sum  [wlld_pkg::SERVERS];
    logic [wlld_pkg::COST_W-1:0] best_cost;

    // Costs and candidate loads; only the back server has its own weights.
    always_comb
    begin
        for (int i = 0; i < wlld_pkg::SERVERS; i++)
        begin
            cost[i] = wlld_pkg::cost_of(
                wlld_pkg::weight_of(weights, (i == wlld_pkg::SERVERS - 1), kind), len);
            sum[i]  = {1'b0, loads[i]} + wlld_pkg::SUM_W'(cost[i]);
        end
    end

    // Smallest sum wins; on equal sums the smaller cost, then the lower index.
    always_comb
    begin
        pick.server = wlld_pkg::SRV_FIRST;
        pick.sum    = sum[0];
        best_cost   = cost[0];
        if (sum[1] < pick.sum || (sum[1] == pick.sum && cost[1] < best_cost))
        begin
            pick.server = wlld_pkg::SRV_ONE;
            pick.sum    = sum[1];
            best_cost   = cost[1];
        end
        if (sum[2] < pick.sum || (sum[2] == pick.sum && cost[2] < best_cost))
        begin
            pick.server = wlld_pkg::SRV_BACK;
            pick.sum    = sum[2];
            best_cost   = cost[2];
        end
    end

endmodule

### design/weighted_least_load_dispatcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_least_load_dispatcher
// Sends typed requests to the least loaded of three servers and retires them.
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   command  start, busy             action, request_kind, request_length,
//                                    target_server
//   result   done (one-cycle strobe) chosen_server, status, done_kind,
//                                    done_length, load_after
//   config   cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A command beat is taken when start is high and busy is low. The next cycle
// works on it with the head entry of the named queue read from the store; its
// result is strobed on done in the cycle after, so no new beat is taken while
// one is worked on, as the pending request store has a registered read port.
// Reset clears loads, queue pointers and full flags and restores the default
// weights; the store itself needs no clearing. The receiver cannot stall.
// ----------------------------------------------------------------------------
module weighted_least_load_dispatcher #(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [1:0]                        request_kind,
    input  logic [3:0]                        request_length,
    input  logic [1:0]                        target_server,
    output logic                              done,
    output logic [1:0]                        chosen_server,
    output logic [2:0]                        status,
    output logic [1:0]                        done_kind,
    output logic [3:0]                        done_length,
    output logic [15:0]                       load_after,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [2:0]                        cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Captured command beat.
    logic                              act_reg;
    logic [wlld_pkg::KIND_W-1:0]       kind_reg;
    logic [wlld_pkg::LEN_W-1:0]        len_reg;
    logic [wlld_pkg::SRV_W-1:0]        tgt_reg;

    // Server state.
    wlld_pkg::loads_t                  load_reg, load_next;
    logic [PTR_W-1:0]                  head_reg [wlld_pkg::SERVERS];
    logic [PTR_W-1:0]                  head_next [wlld_pkg::SERVERS];
    logic [PTR_W-1:0]                  tail_reg [wlld_pkg::SERVERS];
    logic [PTR_W-1:0]                  tail_next [wlld_pkg::SERVERS];
    logic [wlld_pkg::SERVERS-1:0]      full_reg, full_next;

    // Result register.
    logic                              done_reg, done_next;
    logic [wlld_pkg::SRV_W-1:0]        idx_reg, idx_next;
    logic [wlld_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [wlld_pkg::KIND_W-1:0]       dkind_reg, dkind_next;
    logic [wlld_pkg::LEN_W-1:0]        dlen_reg, dlen_next;
    logic [wlld_pkg::LOAD_W-1:0]       lout_reg, lout_next;

    // Store ports and helpers.
    logic                              accept;
    logic [wlld_pkg::SRV_W-1:0]        rd_srv;
    logic [wlld_pkg::ENTRY_W-1:0]      rd_data;
    logic                              wr_en;
    logic [wlld_pkg::SRV_W-1:0]        wr_srv;
    logic [PTR_W-1:0]                  wr_ptr;
    logic [wlld_pkg::ENTRY_W-1:0]      wr_data;
    wlld_pkg::weights_t                weights;
    wlld_pkg::pick_t                   pick;
    logic [wlld_pkg::SRV_W-1:0]        pop_srv;
    logic [wlld_pkg::KIND_W-1:0]       pop_kind;
    logic [wlld_pkg::LEN_W-1:0]        pop_len;
    logic [wlld_pkg::COST_W-1:0]       pop_cost;
    logic [PTR_W-1:0]                  tail_inc;
    logic [PTR_W-1:0]                  head_inc;

    assign accept = start && !busy;
    assign busy   = (state_reg == S_EXEC);

    wlld_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .weights   (weights)
    );

    // The head entry of the named server is read as the beat is taken.
    assign rd_srv = (target_server == wlld_pkg::SRV_NONE) ? wlld_pkg::SRV_FIRST
                                                          : target_server;

    wlld_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_srv  (wr_srv),
        .wr_ptr  (wr_ptr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_srv  (rd_srv),
        .rd_ptr  (head_reg[rd_srv]),
        .rd_data (rd_data)
    );

    wlld_pick u_pick (
        .weights (weights),
        .loads   (load_reg),
        .kind    (kind_reg),
        .len     (len_reg),
        .pick    (pick)
    );

    // Popped entry and its cost under the current weights.
    assign pop_kind = rd_data[wlld_pkg::ENTRY_W-1:wlld_pkg::LEN_W];
    assign pop_len  = rd_data[wlld_pkg::LEN_W-1:0];
    assign pop_cost = wlld_pkg::cost_of(
        wlld_pkg::weight_of(weights, (tgt_reg == wlld_pkg::SRV_BACK), pop_kind), pop_len);

    // Queue named by the captured beat, kept in range for the pointer lookup.
    assign pop_srv = (tgt_reg == wlld_pkg::SRV_NONE) ? wlld_pkg::SRV_FIRST : tgt_reg;

    // Pointer advance with wrap at the queue depth.
    assign tail_inc = (tail_reg[pick.server] == PTR_LAST) ? '0
                                                          : tail_reg[pick.server] + PTR_W'(1);
    assign head_inc = (head_reg[pop_srv] == PTR_LAST) ? '0
                                                      : head_reg[pop_srv] + PTR_W'(1);

    // Sequencer and read-modify-write of the server state.
    always_comb
    begin
        state_next  = state_reg;
        load_next   = load_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        full_next   = full_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        status_next = status_reg;
        dkind_next  = dkind_reg;
        dlen_next   = dlen_reg;
        lout_next   = lout_reg;
        wr_en       = 1'b0;
        wr_srv      = pick.server;
        wr_ptr      = tail_reg[pick.server];
        wr_data     = {kind_reg, len_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                dkind_next = wlld_pkg::KIND_M;
                dlen_next  = '0;
                if (act_reg == wlld_pkg::ACT_DISPATCH)
                begin
                    if (kind_reg == wlld_pkg::KIND_BAD)
                    begin
                        idx_next    = wlld_pkg::SRV_FIRST;
                        status_next = wlld_pkg::ST_BAD_KIND;
                        lout_next   = '0;
                    end
                    else if (full_reg[pick.server])
                    begin
                        idx_next    = pick.server;
                        status_next = wlld_pkg::ST_FULL;
                        lout_next   = load_reg[pick.server];
                    end
                    else
                    begin
                        wr_en                  = 1'b1;
                        tail_next[pick.server] = tail_inc;
                        if (tail_inc == head_reg[pick.server])
                        begin
                            full_next[pick.server] = 1'b1;
                        end
                        load_next[pick.server] = pick.sum[wlld_pkg::SUM_W-1]
                            ? {wlld_pkg::LOAD_W{1'b1}}
                            : pick.sum[wlld_pkg::LOAD_W-1:0];
                        idx_next    = pick.server;
                        status_next = wlld_pkg::ST_DISPATCHED;
                        lout_next   = load_next[pick.server];
                    end
                end
                else
                begin
                    idx_next = tgt_reg;
                    if (tgt_reg == wlld_pkg::SRV_NONE)
                    begin
                        status_next = wlld_pkg::ST_EMPTY;
                        lout_next   = '0;
                    end
                    else if (head_reg[tgt_reg] == tail_reg[tgt_reg] && !full_reg[tgt_reg])
                    begin
                        status_next = wlld_pkg::ST_EMPTY;
                        lout_next   = load_reg[tgt_reg];
                    end
                    else
                    begin
                        head_next[tgt_reg] = head_inc;
                        full_next[tgt_reg] = 1'b0;
                        load_next[tgt_reg] =
                            (load_reg[tgt_reg] >= wlld_pkg::LOAD_W'(pop_cost))
                            ? load_reg[tgt_reg] - wlld_pkg::LOAD_W'(pop_cost)
                            : '0;
                        status_next = wlld_pkg::ST_COMPLETED;
                        dkind_next  = pop_kind;
                        dlen_next   = pop_len;
                        lout_next   = load_next[tgt_reg];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            load_reg  <= '0;
            full_reg  <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < wlld_pkg::SERVERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            load_reg  <= load_next;
            full_reg  <= full_next;
            done_reg  <= done_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    // Captured command and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= action;
            kind_reg <= request_kind;
            len_reg  <= request_length;
            tgt_reg  <= target_server;
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        dkind_reg  <= dkind_next;
        dlen_reg   <= dlen_next;
        lout_reg   <= lout_next;
    end

    assign done          = done_reg;
    assign chosen_server = idx_reg;
    assign status        = status_reg;
    assign done_kind     = dkind_reg;
    assign done_length   = dlen_reg;
    assign load_after    = lout_reg;

    // A taken beat is worked on in the very next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted beat did not enter the work cycle");

    // The work state ends in exactly one result strobe, and busy is low again when done is high.
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("work cycle did not end in a result");

    // No result without a preceding work cycle.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without work");

    // A set full flag implies equal head and tail pointers for the same server.
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (!full_reg[0] || head_reg[0] == tail_reg[0]) &&
        (!full_reg[1] || head_reg[1] == tail_reg[1]) &&
        (!full_reg[2] || head_reg[2] == tail_reg[2]))
        else $error("full flag set with unequal pointers");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted least-load dispatcher. A queue of
// command beats, filled by the sequencer, feeds a clocked driver that also
// keeps a cycle-true model of loads, queues and weights; every taken beat
// yields one predicted outcome, and a clocked monitor matches each result
// strobe field by field against the oldest prediction. Weights are changed
// only between phases while the block is idle. A directed opening covers
// the corner cases, then random phases sweep several weight sets, and a
// pumping sequence drives all queues full before a closing stretch.
// ----------------------------------------------------------------------------
module tb;

    localparam int          QDEPTH      = 256;
    localparam int          CLK_HALF    = 2;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          IDLE_PAD    = 4;

    // Weights restored by reset.
    localparam wlld_pkg::weights_t DEFAULT_WEIGHTS = '{m_front: 3'd2, p_front: 3'd1,
                                                       v_front: 3'd1, m_back: 3'd1,
                                                       p_back: 3'd2, v_back: 3'd3};

    // One command beat as presented on the input ports.
    typedef struct packed {
        logic                        act;
        logic [wlld_pkg::KIND_W-1:0] kind;
        logic [wlld_pkg::LEN_W-1:0]  len;
        logic [wlld_pkg::SRV_W-1:0]  srv;
    } command_t;

    // One result beat as seen on the output ports.
    typedef struct packed {
        logic [wlld_pkg::SRV_W-1:0]    server;
        logic [wlld_pkg::STATUS_W-1:0] status;
        logic [wlld_pkg::KIND_W-1:0]   kind;
        logic [wlld_pkg::LEN_W-1:0]    len;
        logic [wlld_pkg::LOAD_W-1:0]   load;
    } outcome_t;

    logic                           clk;
    logic                           rst_n          = 1'b0;
    logic                           start          = 1'b0;
    logic                           busy;
    logic                           action         = wlld_pkg::ACT_DISPATCH;
    logic [wlld_pkg::KIND_W-1:0]    request_kind   = wlld_pkg::KIND_M;
    logic [wlld_pkg::LEN_W-1:0]     request_length = '0;
    logic [wlld_pkg::SRV_W-1:0]     target_server  = wlld_pkg::SRV_FIRST;
    logic                           done;
    logic [wlld_pkg::SRV_W-1:0]     chosen_server;
    logic [wlld_pkg::STATUS_W-1:0]  status;
    logic [wlld_pkg::KIND_W-1:0]    done_kind;
    logic [wlld_pkg::LEN_W-1:0]     done_length;
    logic [wlld_pkg::LOAD_W-1:0]    load_after;
    logic                           cfg_valid      = 1'b0;
    logic                           cfg_ready;
    logic [wlld_pkg::CFG_IDX_W-1:0] cfg_index      = wlld_pkg::CFG_M_FRONT;
    logic [wlld_pkg::WGT_W-1:0]     cfg_data       = '0;

    // Beats waiting to be driven and outcomes waiting to be seen.
    command_t cmd_backlog[$];
    outcome_t outcome_fifo[$];

    // Model of the dispatcher state.
    wlld_pkg::weights_t           cur_wt;
    logic [wlld_pkg::LOAD_W-1:0]  srv_load [wlld_pkg::SERVERS];
    logic [wlld_pkg::ENTRY_W-1:0] srv_store [wlld_pkg::SERVERS][QDEPTH];
    int unsigned                  q_head [wlld_pkg::SERVERS];
    int unsigned                  q_count [wlld_pkg::SERVERS];

    int unsigned gap_pct = 0;
    int unsigned gap_left = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    weighted_least_load_dispatcher #(
        .QUEUE_DEPTH(QDEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .request_kind   (request_kind),
        .request_length (request_length),
        .target_server  (target_server),
        .done           (done),
        .chosen_server  (chosen_server),
        .status         (status),
        .done_kind      (done_kind),
        .done_length    (done_length),
        .load_after     (load_after),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Weight of a request kind on a given server under the current settings.
    function automatic logic [wlld_pkg::WGT_W-1:0] weight_for(
        input int srv, input logic [wlld_pkg::KIND_W-1:0] kind);
        logic back;
        back = (srv == int'(wlld_pkg::SRV_BACK));
        unique case (kind)
            wlld_pkg::KIND_M: return back ? cur_wt.m_back : cur_wt.m_front;
            wlld_pkg::KIND_P: return back ? cur_wt.p_back : cur_wt.p_front;
            default:          return back ? cur_wt.v_back : cur_wt.v_front;
        endcase
    endfunction

    // Apply one command to the model and return the outcome it must produce.
    function automatic outcome_t predict_outcome(input command_t c);
        outcome_t                     r;
        logic [wlld_pkg::SUM_W-1:0]   sum;
        logic [wlld_pkg::SUM_W-1:0]   best_sum;
        logic [wlld_pkg::COST_W-1:0]  cost;
        logic [wlld_pkg::COST_W-1:0]  best_cost;
        int                           best;
        int                           tgt;
        logic [wlld_pkg::ENTRY_W-1:0] entry;
        r = '0;
        best = 0;
        best_sum = '0;
        best_cost = '0;
        if (c.act == wlld_pkg::ACT_DISPATCH)
        begin
            if (c.kind == wlld_pkg::KIND_BAD)
            begin
                r.status = wlld_pkg::ST_BAD_KIND;
                return r;
            end
            // Lowest load plus cost; equal sums go to the cheaper, then the lower index.
            for (int s = 0; s < wlld_pkg::SERVERS; s++)
            begin
                cost = wlld_pkg::COST_W'(weight_for(s, c.kind)) * wlld_pkg::COST_W'(c.len);
                sum = wlld_pkg::SUM_W'(srv_load[s]) + wlld_pkg::SUM_W'(cost);
                if (s == 0 || sum < best_sum || (sum == best_sum && cost < best_cost))
                begin
                    best = s;
                    best_sum = sum;
                    best_cost = cost;
                end
            end
            r.server = wlld_pkg::SRV_W'(best);
            if (q_count[best] == QDEPTH)
            begin
                r.status = wlld_pkg::ST_FULL;
                r.load = srv_load[best];
                return r;
            end
            srv_store[best][(q_head[best] + q_count[best]) % QDEPTH] = {c.kind, c.len};
            q_count[best]++;
            // The load register saturates rather than wrapping.
            srv_load[best] = best_sum[wlld_pkg::LOAD_W] ? '1
                                                        : best_sum[wlld_pkg::LOAD_W-1:0];
            r.status = wlld_pkg::ST_DISPATCHED;
            r.load = srv_load[best];
            return r;
        end
        r.server = c.srv;
        if (c.srv == wlld_pkg::SRV_NONE)
        begin
            r.status = wlld_pkg::ST_EMPTY;
            return r;
        end
        tgt = int'(c.srv);
        if (q_count[tgt] == 0)
        begin
            r.status = wlld_pkg::ST_EMPTY;
            r.load = srv_load[tgt];
            return r;
        end
        // Retire the oldest request; its cost uses the weights in force now.
        entry = srv_store[tgt][q_head[tgt]];
        q_head[tgt] = (q_head[tgt] + 1) % QDEPTH;
        q_count[tgt]--;
        cost = wlld_pkg::COST_W'(weight_for(tgt, entry[5:4])) * wlld_pkg::COST_W'(entry[3:0]);
        srv_load[tgt] = (srv_load[tgt] >= wlld_pkg::LOAD_W'(cost))
                        ? srv_load[tgt] - wlld_pkg::LOAD_W'(cost) : '0;
        r.status = wlld_pkg::ST_COMPLETED;
        r.kind = entry[5:4];
        r.len = entry[3:0];
        r.load = srv_load[tgt];
        return r;
    endfunction

    // Driver: presents queued beats, inserts idle bursts and tracks taken beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cur_wt = DEFAULT_WEIGHTS;
            for (int s = 0; s < wlld_pkg::SERVERS; s++)
            begin
                srv_load[s] = '0;
                q_head[s] = 0;
                q_count[s] = 0;
            end
            gap_left = 0;
        end
        else
        begin
            // Register writes only happen while idle, so order against beats is moot.
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wlld_pkg::CFG_M_FRONT: cur_wt.m_front = cfg_data;
                    wlld_pkg::CFG_P_FRONT: cur_wt.p_front = cfg_data;
                    wlld_pkg::CFG_V_FRONT: cur_wt.v_front = cfg_data;
                    wlld_pkg::CFG_M_BACK:  cur_wt.m_back = cfg_data;
                    wlld_pkg::CFG_P_BACK:  cur_wt.p_back = cfg_data;
                    wlld_pkg::CFG_V_BACK:  cur_wt.v_back = cfg_data;
                    default:               ;
                endcase
            end
            if (start && !busy)
                outcome_fifo.push_back(predict_outcome(cmd_backlog.pop_front()));
            // A beat that is presented but not yet taken stays as it is.
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (cmd_backlog.size() == 0)
                    start <= 1'b0;
                else if (gap_pct != 0 && $urandom_range(99) < gap_pct)
                begin
                    gap_left = $urandom_range(7, 1) - 1;
                    start <= 1'b0;
                end
                else
                begin
                    start <= 1'b1;
                    action <= cmd_backlog[0].act;
                    request_kind <= cmd_backlog[0].kind;
                    request_length <= cmd_backlog[0].len;
                    target_server <= cmd_backlog[0].srv;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [wlld_pkg::LOAD_W-1:0] want,
                               input logic [wlld_pkg::LOAD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: outputs are stable mid-cycle, so sample the strobe on the falling edge.
    always @(negedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (outcome_fifo.size() == 0)
            begin
                $display("%0t: result with nothing expected: server %0d status %0d load %0d",
                         $time, chosen_server, status, load_after);
                fail_count++;
            end
            else
            begin
                want = outcome_fifo.pop_front();
                check_field("chosen_server", wlld_pkg::LOAD_W'(want.server),
                            wlld_pkg::LOAD_W'(chosen_server));
                check_field("status", wlld_pkg::LOAD_W'(want.status),
                            wlld_pkg::LOAD_W'(status));
                check_field("done_kind", wlld_pkg::LOAD_W'(want.kind),
                            wlld_pkg::LOAD_W'(done_kind));
                check_field("done_length", wlld_pkg::LOAD_W'(want.len),
                            wlld_pkg::LOAD_W'(done_length));
                check_field("load_after", want.load, load_after);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run stopped, no progress within the cycle limit", $time);
            $display("weighted_least_load_dispatcher test failed");
            $finish;
        end
    end

    task automatic queue_cmd(input logic act, input logic [wlld_pkg::KIND_W-1:0] kind,
                             input logic [wlld_pkg::LEN_W-1:0] len,
                             input logic [wlld_pkg::SRV_W-1:0] srv);
        command_t c;
        c = '{act: act, kind: kind, len: len, srv: srv};
        cmd_backlog.push_back(c);
    endtask

    // Random beats: dispatch share, shortest length and share of odd cases in percent.
    task automatic queue_mix(input int unsigned n, input int unsigned dispatch_pct,
                             input int unsigned min_len, input int unsigned odd_pct);
        command_t c;
        repeat (n)
        begin
            c.len = wlld_pkg::LEN_W'($urandom_range(15, min_len));
            if ($urandom_range(99) < dispatch_pct)
            begin
                c.act = wlld_pkg::ACT_DISPATCH;
                c.kind = ($urandom_range(99) < odd_pct) ? wlld_pkg::KIND_BAD
                                                        : wlld_pkg::KIND_W'($urandom_range(2));
                c.srv = wlld_pkg::SRV_W'($urandom_range(3));
            end
            else
            begin
                c.act = wlld_pkg::ACT_COMPLETE;
                c.kind = wlld_pkg::KIND_W'($urandom_range(3));
                c.srv = ($urandom_range(99) < odd_pct) ? wlld_pkg::SRV_NONE
                                                       : wlld_pkg::SRV_W'($urandom_range(2));
            end
            cmd_backlog.push_back(c);
        end
    endtask

    // Wait until every beat is taken and answered, then let the pipeline settle.
    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || outcome_fifo.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAD) @(posedge clk);
    endtask

    // One register write; valid stays high for a following write.
    task automatic put_reg(input logic [wlld_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wlld_pkg::WGT_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_weights(input wlld_pkg::weights_t w);
        put_reg(wlld_pkg::CFG_M_FRONT, w.m_front);
        put_reg(wlld_pkg::CFG_P_FRONT, w.p_front);
        put_reg(wlld_pkg::CFG_V_FRONT, w.v_front);
        put_reg(wlld_pkg::CFG_M_BACK, w.m_back);
        put_reg(wlld_pkg::CFG_P_BACK, w.p_back);
        put_reg(wlld_pkg::CFG_V_BACK, w.v_back);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input wlld_pkg::weights_t w, input int unsigned gaps);
        set_weights(w);
        gap_pct = gaps;
        queue_mix(100, 55, 0, 8);
        wait_idle();
    endtask

    // Sequencer.
    initial
    begin
        wlld_pkg::weights_t w;
        logic [31:0]        rnd;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corner cases under the reset weights.
        gap_pct = 30;
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_BAD, 4'd15, wlld_pkg::SRV_NONE);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_BAD, 4'd15, wlld_pkg::SRV_NONE);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_M, 4'd15, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_P, 4'd15, wlld_pkg::SRV_BACK);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_V, 4'd5, wlld_pkg::SRV_ONE);
        // Equal sums, the cheaper server wins.
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_M, 4'd10, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_V, 4'd15, wlld_pkg::SRV_NONE);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_BAD, 4'd15, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_P, 4'd7, wlld_pkg::SRV_ONE);
        wait_idle();

        // A heavier back weight makes the retiring cost exceed the load.
        w = DEFAULT_WEIGHTS;
        w.m_back = 3'd7;
        set_weights(w);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_BACK);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_BACK);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_M, 4'd0, wlld_pkg::SRV_BACK);
        queue_cmd(wlld_pkg::ACT_DISPATCH, wlld_pkg::KIND_P, 4'd1, wlld_pkg::SRV_FIRST);
        queue_cmd(wlld_pkg::ACT_COMPLETE, wlld_pkg::KIND_V, 4'd8, wlld_pkg::SRV_ONE);
        wait_idle();

        // Random traffic over extreme and random weight sets.
        random_phase('0, 25);
        random_phase('1, 0);
        rnd = $urandom;
        w = rnd[$bits(wlld_pkg::weights_t)-1:0];
        random_phase(w, 40);
        rnd = $urandom;
        w = rnd[$bits(wlld_pkg::weights_t)-1:0];
        random_phase(w, 15);

        // Pump: costly dispatches fill every queue, then free traffic drains a part.
        gap_pct = 20;
        set_weights('1);
        queue_mix(780, 100, 15, 0);
        wait_idle();
        gap_pct = 15;
        set_weights('0);
        queue_mix(100, 50, 0, 5);
        wait_idle();

        // Closing stretch without idling.
        gap_pct = 0;
        rnd = $urandom;
        w = rnd[$bits(wlld_pkg::weights_t)-1:0];
        set_weights(w);
        queue_mix(200, 30, 0, 8);
        wait_idle();
        repeat (IDLE_PAD) @(posedge clk);

        if (fail_count == 0)
            $display("weighted_least_load_dispatcher test passed");
        else
            $display("weighted_least_load_dispatcher test failed");
        $finish;
    end

endmodule
